### hw/rtl/pawq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pawq_pkg: shared types and constants of the availability window query core
// Widths of the item fields, table size, datapath operation codes and the
// command, status and result groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package pawq_pkg;

    localparam int MAX_ELEMENTS = 16;

    localparam int IDX_W  = 4;   // element_index
    localparam int LEN_W  = 16;  // work_length, rest_length
    localparam int TIME_W = 31;  // start_time, query_time, job_length
    localparam int CNT_W  = 5;   // element_count, scan counter
    localparam int ACC_W  = 22;  // calendar length and window offsets
    localparam int DIV_STEPS = TIME_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TIME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUM,
        OP_CHECK,
        OP_DIV,
        OP_WALK1,
        OP_WALK2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic sum_last;
        logic plan_empty;
        logic before_start;
        logic div_last;
        logic walk1_break;
        logic fits_now;
        logic scan_hit;
        logic scan_end;
    } status_t;

    typedef struct packed {
        logic              start_found;
        logic [ACC_W-1:0]  nearest_start;
        logic [LEN_W-1:0]  work_remaining;
        logic [TIME_W-1:0] wait_until_work;
        logic              ready_res;
        logic              empty_plan;
    } result_t;

endpackage : pawq_pkg
`default_nettype wire

### hw/rtl/pawq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pawq_dp: datapath of the availability window query core
// Configuration registers, window tables, calendar sum, bit-serial modulo and
// the two table walks, each stepped by the controller's operation code.
// ----------------------------------------------------------------------------
module pawq_dp import pawq_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_command,
    input  wire logic [IDX_W-1:0]      in_element_index,
    input  wire logic [LEN_W-1:0]      in_work_length,
    input  wire logic [LEN_W-1:0]      in_rest_length,
    input  wire logic [TIME_W-1:0]     in_query_time,
    input  wire logic [TIME_W-1:0]     in_job_length,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output result_t                    result
);

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    logic [TIME_W-1:0] start_time_reg;
    logic [CNT_W-1:0]  element_count_reg;

    logic [LEN_W-1:0] work_mem [MAX_ELEMENTS];
    logic [LEN_W-1:0] rest_mem [MAX_ELEMENTS];

    logic [TIME_W-1:0] qtime_reg;
    logic [TIME_W-1:0] job_reg;
    logic [TIME_W-1:0] tsh_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  dist_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    result_t           res_reg;

    logic [CNT_W-1:0] n_used;
    logic [CNT_W-1:0] n_last;
    logic [LEN_W-1:0] work_rd;
    logic [LEN_W-1:0] rest_rd;
    logic [IDX_W-1:0] idx_wrap;
    logic [ACC_W:0]   div_shift;
    logic [ACC_W:0]   div_diff;
    logic             div_ge;
    logic [ACC_W-1:0] rem_step;
    logic             in_work;
    logic             in_rest;
    logic [ACC_W-1:0] past_work;
    logic [ACC_W-1:0] rem_sub;
    logic [LEN_W-1:0] work_left;
    logic [LEN_W-1:0] rest_left;
    logic             fits;

    // Counts above the table size use the whole table.
    assign n_used = (element_count_reg > MAX_CNT) ? MAX_CNT : element_count_reg;
    assign n_last = n_used - CNT_W'(1);

    assign work_rd  = work_mem[idx_reg];
    assign rest_rd  = rest_mem[idx_reg];
    assign idx_wrap = ({1'b0, idx_reg} == n_last) ? '0 : idx_reg + IDX_W'(1);

    // One restoring step of the modulo by the calendar length.
    assign div_shift = {rem_reg, tsh_reg[TIME_W-1]};
    assign div_diff  = div_shift - {1'b0, acc_reg};
    assign div_ge    = (div_shift >= {1'b0, acc_reg});
    assign rem_step  = div_ge ? div_diff[ACC_W-1:0] : div_shift[ACC_W-1:0];

    // Position within the current pair of windows.
    assign in_work   = (rem_reg < ACC_W'(work_rd));
    assign past_work = rem_reg - ACC_W'(work_rd);
    assign in_rest   = !in_work && (past_work < ACC_W'(rest_rd));
    assign rem_sub   = past_work - ACC_W'(rest_rd);
    assign work_left = work_rd - rem_reg[LEN_W-1:0];
    assign rest_left = rest_rd - past_work[LEN_W-1:0];
    assign fits      = (TIME_W'(work_left) >= job_reg);

    always_comb begin
        status.n_zero       = (n_used == '0);
        status.sum_last     = ({1'b0, idx_reg} == n_last);
        status.plan_empty   = (acc_reg == '0);
        status.before_start = (qtime_reg < start_time_reg);
        status.div_last     = (cnt_reg == DIV_LAST);
        status.walk1_break  = in_work || in_rest;
        status.fits_now     = in_work && fits;
        status.scan_hit     = (TIME_W'(work_rd) >= job_reg);
        status.scan_end     = (cnt_reg == n_used);
    end

    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg    <= '0;
            element_count_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_TIME:    start_time_reg    <= cfg_data;
                CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD && in_command == CMD_WRITE
            && {1'b0, in_element_index} < MAX_CNT) begin
            work_mem[in_element_index] <= in_work_length;
            rest_mem[in_element_index] <= in_rest_length;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                qtime_reg <= in_query_time;
                job_reg   <= in_job_length;
                acc_reg   <= '0;
                idx_reg   <= '0;
                res_reg   <= '0;
            end
            OP_SUM: begin
                acc_reg <= acc_reg + ACC_W'(work_rd) + ACC_W'(rest_rd);
                idx_reg <= idx_reg + IDX_W'(1);
            end
            OP_CHECK: begin
                if (status.plan_empty) begin
                    res_reg.empty_plan <= 1'b1;
                end else if (status.before_start) begin
                    res_reg.wait_until_work <= start_time_reg - qtime_reg;
                    res_reg.start_found     <= 1'b1;
                end else begin
                    tsh_reg <= qtime_reg - start_time_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            OP_DIV: begin
                rem_reg <= rem_step;
                tsh_reg <= {tsh_reg[TIME_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (status.div_last) begin
                    idx_reg <= '0;
                end
            end
            OP_WALK1: begin
                if (in_work) begin
                    res_reg.ready_res      <= 1'b1;
                    res_reg.work_remaining <= work_left;
                    dist_reg <= ACC_W'(work_left) + ACC_W'(rest_rd);
                    idx_reg  <= idx_wrap;
                    cnt_reg  <= '0;
                    if (fits) begin
                        res_reg.start_found <= 1'b1;
                    end
                end else if (in_rest) begin
                    res_reg.wait_until_work <= TIME_W'(rest_left);
                    dist_reg <= ACC_W'(rest_left);
                    idx_reg  <= idx_wrap;
                    cnt_reg  <= '0;
                end else begin
                    rem_reg <= rem_sub;
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            OP_WALK2: begin
                if (status.scan_hit) begin
                    res_reg.nearest_start <= dist_reg;
                    res_reg.start_found   <= 1'b1;
                end else begin
                    dist_reg <= dist_reg + ACC_W'(work_rd) + ACC_W'(rest_rd);
                    idx_reg  <= idx_wrap;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

endmodule : pawq_dp
`default_nettype wire

### hw/rtl/pawq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pawq_ctrl: sequencer of the availability window query core
// Steps one item at a time through sum, check, modulo and the table walks,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module pawq_ctrl import pawq_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    input  wire logic    in_command,
    input  wire logic    out_free,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_WALK1,
        ST_WALK2,
        ST_EMIT
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.op   = OP_NONE;
        cmd.emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_SUM:   cmd.op = OP_SUM;
            ST_CHECK: cmd.op = OP_CHECK;
            ST_DIV:   cmd.op = OP_DIV;
            ST_WALK1: cmd.op = OP_WALK1;
            ST_WALK2: cmd.op = OP_WALK2;
            ST_EMIT:  cmd.emit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid && in_command == CMD_QUERY) begin
                        state_reg <= status.n_zero ? ST_CHECK : ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (status.sum_last) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (status.plan_empty || status.before_start) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (status.div_last) begin
                        state_reg <= ST_WALK1;
                    end
                end
                ST_WALK1: begin
                    if (status.walk1_break) begin
                        state_reg <= status.fits_now ? ST_EMIT : ST_WALK2;
                    end
                end
                ST_WALK2: begin
                    if (status.scan_hit || status.scan_end) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule : pawq_ctrl
`default_nettype wire

### hw/rtl/periodic_availability_window_query_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_availability_window_query_core: repeating work/rest calendar query
// Holds up to sixteen work/rest window pairs and answers availability queries
// against the calendar that they form from a configured start time onwards.
// ----------------------------------------------------------------------------
// The block takes one input transfer at a time. A write transfer loads one
// window pair and is finished in the cycle it is taken. A query sums the
// calendar length over the pairs in use, checks for an empty plan or a time
// before the start and, if neither holds, runs the bit-serial modulo of the
// elapsed time by the calendar length, locates the current window and, unless
// the job fits there, scans for a window long enough for the job, then passes
// the result to the output register once it is free. The result waits in its
// own output register, so the next transfer is taken while a result is still
// waiting for the downstream side. Configuration writes are expected only
// while the block is idle; the configuration channel is always ready.
// ----------------------------------------------------------------------------
module periodic_availability_window_query_core import pawq_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write channel: index 0 start_time, index 1 element_count.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata, lowest bit up: element_index[3:0], work_length[19:4],
    // rest_length[35:20], query_time[66:36], job_length[97:67], zero pad.
    input  wire logic [103:0]          s_tdata,
    // tuser: command (0 write a pair, 1 query).
    input  wire logic                  s_tuser,

    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata, lowest bit up: ready_res[0], wait_until_work[31:1],
    // work_remaining[47:32], nearest_start[69:48], start_found[70], zero pad.
    output logic [71:0]                m_tdata,
    // tuser: empty_plan.
    output logic                       m_tuser
);

    cmd_t    cmd;
    status_t status;
    result_t result;

    logic    m_valid_reg;
    result_t m_res_reg;
    logic    out_free;

    assign cfg_ready = 1'b1;

    // The output register is free when empty or when its transfer completes now.
    assign out_free = !m_valid_reg || m_tready;

    pawq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .out_free   (out_free),
        .status     (status),
        .in_ready   (s_tready),
        .cmd        (cmd)
    );

    pawq_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_command       (s_tuser),
        .in_element_index (s_tdata[3:0]),
        .in_work_length   (s_tdata[19:4]),
        .in_rest_length   (s_tdata[35:20]),
        .in_query_time    (s_tdata[66:36]),
        .in_job_length    (s_tdata[97:67]),
        .cmd              (cmd),
        .status           (status),
        .result           (result)
    );

    // Output register: loaded when the controller hands over a finished result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.empty_plan;
    assign m_tdata  = {1'b0,
                       m_res_reg.start_found,
                       m_res_reg.nearest_start,
                       m_res_reg.work_remaining,
                       m_res_reg.wait_until_work,
                       m_res_reg.ready_res};

    // An empty plan carries no other information.
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.empty_plan |-> m_tdata == '0)
        else $error("empty plan result carries non-zero fields");

    // Inside a work window there is no wait and some work time is left.
    a_ready_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.ready_res |->
            m_res_reg.wait_until_work == '0 && m_res_reg.work_remaining != '0)
        else $error("ready result with wait time or no remaining work");

    // Without a fitting window the offset stays at zero.
    a_offset_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_res_reg.start_found |-> m_res_reg.nearest_start == '0)
        else $error("nearest start offset given without a fitting window");

    // No input transfer is taken while the controller is handing over a result.
    a_no_accept_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("input taken while a result is handed over");

endmodule : periodic_availability_window_query_core
`default_nettype wire
